[rtl/bm8_pkg.sv]
// Shared types and constants of the block median unit.
`default_nettype none
package bm8_pkg;

   localparam int PIX_W   = 8;
   localparam int SIZE_W  = 11;
   localparam int NUM_BINS = 256;
   localparam logic [PIX_W-1:0]  PIX_MAX = 8'd255;
   localparam logic [SIZE_W-1:0] WINDOW_RESET = 11'd1024;

   typedef enum logic {
      ST_LOAD,
      ST_WALK
   } ctl_state_type;

   typedef struct packed {
      logic take;      // a pixel transfer happens this cycle
      logic walk_rd;   // read the next bin of the cumulative walk
      logic finish;    // load the result and clear the block
   } ctl_cmd_type;

   typedef struct packed {
      logic last_pixel;  // the pixel now offered completes the block
      logic hi_found;    // both central ranks have been located
      logic out_busy;    // the result register is full and stalled
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/block_median_8bit_top.sv]
// Top level of the block median unit for 8-bit pixel streams.
//
// Pixels arrive on the req_ channel (req_valid, req_stall, req_pixel). Every
// window_size pixels the unit delivers one median on the rsp_ channel
// (rsp_valid, rsp_stall, rsp_median). For an odd block the median is the middle
// element; for an even block it is the floor of the mean of the two middle ones.
// window_size is written through csr_we and csr_wdata; the user must do so only
// while the unit is idle, which the unit itself does not enforce. A write
// discards the block in progress. Zero acts as one, and values above MAX_WINDOW
// act as MAX_WINDOW. Pixels of a block are taken one per cycle; each updates a
// 256-bin histogram with a read-modify-write on a store with one read and one
// write port. After the last pixel the unit walks the bins one per cycle up to
// the bin of the upper middle pixel value, then loads the result. req_stall
// stays high during that walk. Reset empties the histogram at once, sets
// window_size to 1024 and drops any pending result. If the receiver stalls a
// result, the next block's walk waits at its end until the result register is
// free.
`default_nettype none
module block_median_8bit_top
   import bm8_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  req_pixel,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PIX_W-1:0]       rsp_median,
   input  wire logic              csr_we,
   input  wire logic [SIZE_W-1:0] csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   bm8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bm8_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_pixel  (req_pixel),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_median (rsp_median),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

[rtl/bm8_ctrl.sv]
// Controller state machine of the block median unit.
`default_nettype none
module bm8_ctrl
   import bm8_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.last_pixel) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!status.hi_found) begin
               cmd.walk_rd = 1'b1;
            end else if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/bm8_datapath.sv]
// Histogram store, cumulative walk and result register of the block median unit.
`default_nettype none
module bm8_datapath
   import bm8_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [PIX_W-1:0]  req_pixel,
   input  wire logic              csr_we,
   input  wire logic [SIZE_W-1:0] csr_wdata,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [PIX_W-1:0]       rsp_median,
   input  wire ctl_cmd_type       cmd,
   output dp_status_type          status
);

   // A bin never counts more than the largest usable block size.
   localparam int CAP = (MAX_WINDOW < 2047) ? MAX_WINDOW : 2047;
   localparam int CW  = $clog2(CAP + 1);

   logic [SIZE_W-1:0] window_size_ff;
   logic [SIZE_W-1:0] eff_size;
   logic [SIZE_W-1:0] rank_hi;
   logic [SIZE_W-1:0] rank_lo;
   logic [SIZE_W-1:0] pixels_taken_ff;
   logic              clear;

   logic [CW-1:0]     bin_mem [NUM_BINS];
   logic [NUM_BINS-1:0] bin_vld_ff;
   logic [PIX_W-1:0]  rd_addr;
   logic [CW-1:0]     rd_data_ff;
   logic              rd_vld_ff;
   logic              bypass;

   logic              inc_vld_ff;
   logic [PIX_W-1:0]  inc_addr_ff;
   logic [CW-1:0]     inc_old;
   logic [CW-1:0]     inc_val;

   logic [PIX_W-1:0]  walk_addr_ff;
   logic              walk_vld_ff;
   logic [PIX_W-1:0]  walk_bin_ff;
   logic [SIZE_W-1:0] cum_ff;
   logic [SIZE_W-1:0] cum_in;
   logic              lo_found_ff;
   logic              hi_found_ff;
   logic [PIX_W-1:0]  lo_ff;
   logic [PIX_W-1:0]  hi_ff;
   logic              walk_eval;
   logic              lo_hit;
   logic              hi_hit;
   logic [PIX_W:0]    mid_sum;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_median_ff;

   assign clear = cmd.finish | csr_we;

   // Configuration register and effective block size.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         window_size_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (window_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (32'(window_size_ff) > 32'(MAX_WINDOW)) begin
         eff_size = SIZE_W'(CAP);
      end else begin
         eff_size = window_size_ff;
      end
      rank_hi = eff_size >> 1;
      rank_lo = eff_size[0] ? rank_hi : rank_hi - SIZE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pixels_taken_ff <= '0;
      end else if (cmd.take) begin
         pixels_taken_ff <= pixels_taken_ff + SIZE_W'(1);
      end
   end

   assign status.last_pixel = ({1'b0, pixels_taken_ff} + (SIZE_W+1)'(1))
                              >= {1'b0, eff_size};

   // Bin store: one read port shared by the increment and the walk.
   // A bin written in the same cycle it is read is taken from the write data.
   assign rd_addr = cmd.take ? req_pixel : walk_addr_ff;
   assign bypass  = inc_vld_ff && (inc_addr_ff == rd_addr);
   assign inc_old = rd_vld_ff ? rd_data_ff : '0;
   assign inc_val = inc_old + CW'(1);

   always_ff @(posedge clock) begin
      if (inc_vld_ff) begin
         bin_mem[inc_addr_ff] <= inc_val;
      end
      rd_data_ff <= bypass ? inc_val : bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         bin_vld_ff <= '0;
      end else if (inc_vld_ff) begin
         bin_vld_ff[inc_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff   <= bypass | bin_vld_ff[rd_addr];
      inc_addr_ff <= req_pixel;
      walk_bin_ff <= walk_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_vld_ff  <= 1'b0;
         walk_vld_ff <= 1'b0;
      end else begin
         inc_vld_ff  <= cmd.take;
         walk_vld_ff <= cmd.walk_rd;
      end
   end

   // Cumulative walk. The last bin always matches, so the walk ends there at the latest.
   assign walk_eval = walk_vld_ff && !hi_found_ff;
   assign cum_in    = cum_ff + SIZE_W'(inc_old);
   assign lo_hit    = (cum_in > rank_lo) || (walk_bin_ff == PIX_MAX);
   assign hi_hit    = (cum_in > rank_hi) || (walk_bin_ff == PIX_MAX);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         walk_addr_ff <= '0;
         cum_ff       <= '0;
         lo_found_ff  <= 1'b0;
         hi_found_ff  <= 1'b0;
      end else begin
         if (cmd.walk_rd) begin
            walk_addr_ff <= walk_addr_ff + PIX_W'(1);
         end
         if (walk_eval) begin
            cum_ff <= cum_in;
            if (!lo_found_ff && lo_hit) begin
               lo_found_ff <= 1'b1;
               lo_ff       <= walk_bin_ff;
            end
            if (hi_hit) begin
               hi_found_ff <= 1'b1;
               hi_ff       <= walk_bin_ff;
            end
         end
      end
   end

   assign status.hi_found = hi_found_ff;

   // Result register.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_median_ff <= mid_sum[PIX_W:1];
      end
   end

   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median      = rsp_median_ff;

   // The last increment is written before the first walk bin is evaluated.
   a_inc_walk_excl: assert property (@(posedge clock) disable iff (reset)
      !(inc_vld_ff && walk_vld_ff))
      else $error("increment and walk evaluation overlap");

   a_finish_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (hi_found_ff && lo_found_ff && !status.out_busy))
      else $error("result loaded before the walk ended or into a full register");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      pixels_taken_ff <= eff_size)
      else $error("pixel count ran past the block size");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result appeared without a finished block");

   a_no_take_walk: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && (cmd.walk_rd || cmd.finish)))
      else $error("pixel transfer during the walk");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of the block median unit: directed table, random phases, predictor.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bm8_pkg::*;

   localparam int MAX_WIN       = 1024;
   localparam int RAND_ITEMS    = 2000;
   localparam int SETTLE_CYCLES = 270;
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int NUM_ROWS      = 25;

   typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_type;
   typedef enum int { PX_UNIFORM, PX_CLUSTER, PX_EXTREME, PX_HIGH } px_mode_type;

   typedef struct packed {
      logic              wr_cfg;
      logic [SIZE_W-1:0] cfg_val;
      logic [PIX_W-1:0]  px;
      logic [SIZE_W-1:0] reps;
      logic              has_typed;
      logic [PIX_W-1:0]  typed_med;
   } stim_row_type;

   // wr_cfg, window, pixel, repeat count, typed expectation present, typed median
   stim_row_type directed_rows [NUM_ROWS] = '{
      // Reset window of 1024: half zeros, half full scale.
      '{1'b0, 11'd0,    8'd0,   11'd512, 1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd255, 11'd512, 1'b1, 8'd127},
      // A zero window acts as a window of one.
      '{1'b1, 11'd0,    8'd255, 11'd1,   1'b1, 8'd255},
      '{1'b0, 11'd0,    8'd0,   11'd1,   1'b1, 8'd0},
      '{1'b1, 11'd1,    8'hA5,  11'd1,   1'b1, 8'hA5},
      '{1'b1, 11'd1,    8'h5A,  11'd1,   1'b1, 8'h5A},
      '{1'b1, 11'd2,    8'd0,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd255, 11'd1,   1'b1, 8'd127},
      '{1'b1, 11'd3,    8'd200, 11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd10,  11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd100, 11'd1,   1'b1, 8'd100},
      '{1'b1, 11'd2,    8'd7,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd7,   11'd1,   1'b1, 8'd7},
      '{1'b1, 11'd4,    8'd4,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd1,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd3,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd2,   11'd1,   1'b1, 8'd2},
      // The pixel of 50 is left in an open block, which the next write discards.
      '{1'b1, 11'd2,    8'd50,  11'd1,   1'b0, 8'd0},
      '{1'b1, 11'd2,    8'd0,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd0,   11'd1,   1'b1, 8'd0},
      '{1'b1, 11'd5,    8'd255, 11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd255, 11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd0,   11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd128, 11'd1,   1'b0, 8'd0},
      '{1'b0, 11'd0,    8'd255, 11'd1,   1'b0, 8'd0}
   };

   int fixed_wins [10] = '{1, 0, 2, 3, 256, 4, 5, 6, 7, 8};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [PIX_W-1:0]  req_pixel;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PIX_W-1:0]  rsp_median;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   int unsigned       hist_model [NUM_BINS];
   int unsigned       pix_in_block;
   logic [SIZE_W-1:0] window_reg;
   logic [PIX_W-1:0]  pending_medians [$];
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   int                mismatch_count = 0;
   longint            cycle_count = 0;
   logic              long_hold_go = 1'b0;

   block_median_8bit_top #(.MAX_WINDOW(MAX_WIN)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_hist();
      foreach (hist_model[i]) hist_model[i] = 0;
      pix_in_block = 0;
   endfunction

   function automatic logic [PIX_W-1:0] value_of_rank(int unsigned rank);
      int unsigned cum;
      cum = 0;
      for (int v = 0; v < NUM_BINS; v++) begin
         cum += hist_model[v];
         if (cum > rank) return PIX_W'(v);
      end
      return PIX_MAX;
   endfunction

   // Tallies one pixel; returns 1 with the median when it closes the block.
   function automatic bit tally_pixel(input logic [PIX_W-1:0] px,
                                      output logic [PIX_W-1:0] med);
      int unsigned size;
      int unsigned lo;
      int unsigned hi;
      size = window_reg;
      if (size == 0) size = 1;
      if (size > MAX_WIN) size = MAX_WIN;
      hist_model[px]++;
      pix_in_block++;
      med = '0;
      if (pix_in_block < size) return 1'b0;
      // An odd block takes the middle rank twice, so the mean leaves it unchanged.
      hi = value_of_rank(size / 2);
      lo = (size % 2 == 1) ? hi : value_of_rank(size / 2 - 1);
      med = PIX_W'((lo + hi) >> 1);
      clear_hist();
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] gen_pixel(px_mode_type mode,
                                                  logic [PIX_W-1:0] base);
      logic [PIX_W-1:0] pick;
      case (mode)
         PX_CLUSTER: pick = base + PIX_W'($urandom_range(3));
         PX_EXTREME: begin
            pick = $urandom_range(1) ? PIX_MAX : '0;
            pick ^= PIX_W'($urandom_range(1));
         end
         PX_HIGH:    pick = PIX_W'($urandom_range(255, 192));
         default:    pick = PIX_W'($urandom_range(255));
      endcase
      return pick;
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] px, input bit use_typed,
                             input logic [PIX_W-1:0] typed_med);
      logic [PIX_W-1:0] med;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tally_pixel(px, med)) pending_medians.push_back(use_typed ? typed_med : med);
      @(negedge clock);
   endtask

   // The unit must be idle for a write: all medians out, and any open block settled.
   task automatic write_window(input logic [SIZE_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      window_reg = value;
      clear_hist();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_medians.size() == 0) begin
            note_mismatch($sformatf("unexpected median transfer: %0d", rsp_median));
         end else begin
            want = pending_medians.pop_front();
            if (rsp_median !== want)
               note_mismatch($sformatf("median mismatch: expected %0d, got %0d",
                                       want, rsp_median));
         end
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (long_hold_go) begin
            // Hold the result channel off long enough for the unit to back up
            // into the pixel channel.
            long_hold_go <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   initial begin
      logic [PIX_W-1:0] base;
      px_mode_type      pmode;
      int               sent;
      int               ph;
      int               win;
      int               size;
      int               count;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      window_reg = WINDOW_RESET;
      clear_hist();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 34;
      rx_idle_pct = 34;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].wr_cfg) write_window(directed_rows[r].cfg_val);
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_pixel(directed_rows[r].px,
                       directed_rows[r].has_typed && (k == directed_rows[r].reps - 1),
                       directed_rows[r].typed_med);
      end

      sent = 0;
      ph = 0;
      while (sent < RAND_ITEMS) begin
         // The first phase writes all ones, which saturates to the largest window.
         if (ph == 0) win = 2047;
         else if (ph <= $size(fixed_wins)) win = fixed_wins[ph - 1];
         else if ($urandom_range(9) == 0) win = $urandom_range(120, 13);
         else win = $urandom_range(12, 1);
         write_window(SIZE_W'(win));
         case (idle_mode_type'((ph + 3) % 4))
            IDLE_NONE: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
            IDLE_SEND: begin
               tx_idle_pct = 82;
               rx_idle_pct = 0;
            end
            IDLE_RECV: begin
               tx_idle_pct = 0;
               rx_idle_pct = 82;
            end
            default: begin
               tx_idle_pct = 34;
               rx_idle_pct = 34;
            end
         endcase
         if (ph == 1) long_hold_go <= 1'b1;
         size = (win == 0) ? 1 : (win > MAX_WIN) ? MAX_WIN : win;
         count = (size >= 48) ? size : size * (48 / size);
         // Sometimes leave a block open so the next write has something to discard.
         if (size > 1 && $urandom_range(1) == 1)
            count += $urandom_range((size > 25) ? 24 : size - 1, 1);
         pmode = px_mode_type'($urandom_range(3));
         base = PIX_W'($urandom);
         repeat (count) begin
            send_pixel(gen_pixel(pmode, base), 1'b0, '0);
            sent++;
         end
         ph++;
      end

      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
rtl/bm8_pkg.sv
rtl/bm8_ctrl.sv
rtl/bm8_datapath.sv
rtl/block_median_8bit_top.sv
dv/tb_top.sv
